/* rtl/sfgc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgc_pkg
// Shared types and constants of the split-frame Gaussian convolution unit.
// ----------------------------------------------------------------------------
package sfgc_pkg;

  localparam int KIND_W    = 2;
  localparam int WIDX_W    = 6;
  localparam int WEIGHT_W  = 16;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 14;
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 13;
  localparam int HALF_W    = 2;

  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAP,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic take;
  } mac_ctrl_t;

endpackage

/* rtl/sfgc_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgc_item_if
// Input and result item channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfgc_in_if;
  logic                            valid;
  logic                            ready;
  logic [sfgc_pkg::KIND_W-1:0]     kind;
  logic [sfgc_pkg::WIDX_W-1:0]     weight_index;
  logic [sfgc_pkg::WEIGHT_W-1:0]   weight_value;
  logic [sfgc_pkg::CHAN_W-1:0]     red_in;
  logic [sfgc_pkg::CHAN_W-1:0]     green_in;
  logic [sfgc_pkg::CHAN_W-1:0]     blue_in;

  modport source (output valid, kind, weight_index, weight_value, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, kind, weight_index, weight_value, red_in, green_in, blue_in,
                output ready);
endinterface

interface sfgc_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfgc_pkg::CHAN_W-1:0] red_out;
  logic [sfgc_pkg::CHAN_W-1:0] green_out;
  logic [sfgc_pkg::CHAN_W-1:0] blue_out;
  logic                        frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

/* rtl/split_frame_gaussian_convolution_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_frame_gaussian_convolution_unit
// Flow: an item that causes a result starts the (2r+1)^2 tap reads, one per cycle;
// the reads pass the registered RAM read, product register and accumulator.
// Throughput: 1 item per cycle while no result is in progress; no item is taken
// until the result is emitted, which waits while the output register is full.
// Reset: synchronous, clears counters and control; line store and kernel RAMs
// are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
module split_frame_gaussian_convolution_unit #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HALF  = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfgc_pkg::CFG_W-1:0]     cfg_data,
  sfgc_in_if.sink                        in_ch,
  sfgc_out_if.source                     out_ch
);

  localparam int KDIM    = 2 * MAX_HALF + 1;
  localparam int NKW     = KDIM * KDIM;
  localparam int SLOTS   = 3 * MAX_HALF + 2;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int SW      = $clog2(SLOTS);
  localparam int SBW     = SW + 2;
  localparam int LAW     = SW + CW;
  localparam int LDEPTH  = SLOTS * (2 ** CW);
  localparam int KAW     = $clog2(NKW);
  localparam int TW      = $clog2(KDIM);
  localparam int RW      = $clog2(MAX_HALF + 1);
  localparam int ACC_W   = sfgc_pkg::PIX_W + $clog2(NKW);
  localparam int LAG_MAX = MAX_HALF * MAX_WIDTH + MAX_HALF + 1;
  localparam int DW      = $clog2(LAG_MAX + 1);
  localparam int RWW     = sfgc_pkg::ROW_W;

  sfgc_pkg::state_t state, state_next;

  logic [sfgc_pkg::IMG_W_W-1:0] image_width;
  logic [sfgc_pkg::IMG_H_W-1:0] image_height;
  logic [sfgc_pkg::HALF_W-1:0]  half_size;

  logic [CW:0]     w_eff, halfw;
  logic [RWW-1:0]  h_eff;
  logic [RW-1:0]   r_eff;
  logic [DW-1:0]   lag;

  logic [RWW-1:0]  in_row, out_row;
  logic [CW:0]     in_col, out_col;
  logic [SW-1:0]   in_slot, out_slot;
  logic [DW-1:0]   lead, lead_inc;

  logic [TW-1:0]   ti, tj, r2;
  logic [KAW-1:0]  kbase;
  logic            v1;

  logic is_acc, row_live, kram_we, lram_we, adv, start, tap_last, emit, frame_last;
  logic in_ready, tap_issue;

  logic [LAW-1:0]  l_raddr;
  logic [sfgc_pkg::PIX_W-1:0]    l_rdata;
  logic [sfgc_pkg::WEIGHT_W-1:0] k_rdata;

  sfgc_pkg::mac_ctrl_t mac_ctrl;
  logic                mac_busy;
  logic [sfgc_pkg::CHAN_W-1:0] m_red, m_green, m_blue;

  logic out_valid;

  // effective settings
  always_comb begin
    logic [13:0] wx;
    logic [3:0]  rx;
    wx = {2'b00, image_width};
    if (wx < 14'd2) begin
      wx = 14'd2;
    end else if (wx > 14'(MAX_WIDTH)) begin
      wx = 14'(MAX_WIDTH);
    end
    w_eff = (CW+1)'(wx);
    halfw = w_eff >> 1;
    h_eff = (image_height == '0) ? RWW'(1) : RWW'(image_height);
    rx = {2'b00, half_size};
    if (rx > 4'(MAX_HALF)) begin
      rx = 4'(MAX_HALF);
    end
    r_eff = RW'(rx);
    lag   = DW'(r_eff) * DW'(w_eff) + DW'(r_eff);
    r2    = TW'({r_eff, 1'b0});
  end

  // item decode
  always_comb begin
    is_acc   = in_ch.valid && in_ready;
    row_live = in_row < h_eff;
    kram_we  = is_acc && (in_ch.kind == sfgc_pkg::KIND_WEIGHT)
               && ({26'd0, in_ch.weight_index} < 32'(NKW));
    lram_we  = is_acc && (in_ch.kind == sfgc_pkg::KIND_PIXEL) && row_live;
    adv      = is_acc && ((in_ch.kind == sfgc_pkg::KIND_PIXEL)
               || ((in_ch.kind == sfgc_pkg::KIND_FLUSH) && !row_live));
    lead_inc = lead + DW'(1);
    start    = adv && (lead_inc > lag);
    tap_last = (ti == r2) && (tj == r2);
    emit     = (state == sfgc_pkg::S_DRAIN) && !v1 && !mac_busy
               && (!out_valid || out_ch.ready);
    frame_last = (out_row == h_eff - RWW'(1)) && (out_col == w_eff - (CW+1)'(1));
  end

  // tap address: row clamp to frame, column clamp to own half
  always_comb begin
    logic [RWW:0]   sy_b, sy;
    logic [RWW:0]   off;
    logic [SBW-1:0] sl;
    logic [CW+1:0]  sx_b, lo_b, hi_b;
    sy_b = (RWW+1)'(out_row) + (RWW+1)'(ti);
    if (sy_b < (RWW+1)'(r_eff)) begin
      sy = '0;
    end else begin
      sy = sy_b - (RWW+1)'(r_eff);
    end
    if (sy > (RWW+1)'(h_eff - RWW'(1))) begin
      sy = (RWW+1)'(h_eff - RWW'(1));
    end
    off = sy + (RWW+1)'(r_eff) - (RWW+1)'(out_row);
    sl  = SBW'(out_slot) + SBW'(SLOTS) + SBW'(off) - SBW'(r_eff);
    if (sl >= SBW'(2 * SLOTS)) begin
      sl = sl - SBW'(2 * SLOTS);
    end else if (sl >= SBW'(SLOTS)) begin
      sl = sl - SBW'(SLOTS);
    end
    if (out_col >= halfw) begin
      lo_b = (CW+2)'(halfw) + (CW+2)'(r_eff);
      hi_b = (CW+2)'(w_eff) - (CW+2)'(1) + (CW+2)'(r_eff);
    end else begin
      lo_b = (CW+2)'(r_eff);
      hi_b = (CW+2)'(halfw) - (CW+2)'(1) + (CW+2)'(r_eff);
    end
    sx_b = (CW+2)'(out_col) + (CW+2)'(tj);
    if (sx_b < lo_b) begin
      sx_b = lo_b;
    end else if (sx_b > hi_b) begin
      sx_b = hi_b;
    end
    sx_b = sx_b - (CW+2)'(r_eff);
    l_raddr = {SW'(sl), sx_b[CW-1:0]};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sfgc_pkg::S_IDLE:  if (start) state_next = sfgc_pkg::S_TAP;
      sfgc_pkg::S_TAP:   if (tap_last) state_next = sfgc_pkg::S_DRAIN;
      sfgc_pkg::S_DRAIN: if (emit) state_next = sfgc_pkg::S_IDLE;
      default:           state_next = sfgc_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    tap_issue = 1'b0;
    case (state)
      sfgc_pkg::S_IDLE: in_ready  = 1'b1;
      sfgc_pkg::S_TAP:  tap_issue = 1'b1;
      default: begin
      end
    endcase
    mac_ctrl.clear = start;
    mac_ctrl.take  = v1;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sfgc_pkg::S_IDLE;
      image_width  <= 12'd1024;
      image_height <= 13'd1024;
      half_size    <= 2'd1;
      in_row <= '0; in_col <= '0; in_slot <= '0;
      out_row <= '0; out_col <= '0; out_slot <= '0;
      lead <= '0;
      ti <= '0; tj <= '0; kbase <= '0;
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= tap_issue;
      if (cfg_we) begin
        case (cfg_index)
          sfgc_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[sfgc_pkg::IMG_W_W-1:0];
          sfgc_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[sfgc_pkg::IMG_H_W-1:0];
          sfgc_pkg::CFG_HALF_SIZE:    half_size    <= cfg_data[sfgc_pkg::HALF_W-1:0];
          default: begin
          end
        endcase
        if (cfg_index == sfgc_pkg::CFG_IMAGE_WIDTH || cfg_index == sfgc_pkg::CFG_IMAGE_HEIGHT
            || cfg_index == sfgc_pkg::CFG_HALF_SIZE) begin
          in_row <= '0; in_col <= '0; in_slot <= '0;
          out_row <= '0; out_col <= '0; out_slot <= '0;
          lead <= '0;
        end
      end
      if (adv) begin
        lead <= lead_inc;
        if (in_col + (CW+1)'(1) >= w_eff) begin
          in_col <= '0;
          in_row <= in_row + RWW'(1);
          in_slot <= (in_slot == SW'(SLOTS - 1)) ? '0 : in_slot + SW'(1);
        end else begin
          in_col <= in_col + (CW+1)'(1);
        end
      end
      if (start) begin
        ti <= '0; tj <= '0; kbase <= '0;
      end
      if (tap_issue) begin
        if (tj == r2) begin
          tj    <= '0;
          ti    <= ti + TW'(1);
          kbase <= kbase + KAW'(KDIM);
        end else begin
          tj <= tj + TW'(1);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
        if (frame_last) begin
          in_row <= '0; in_col <= '0; in_slot <= '0;
          out_row <= '0; out_col <= '0; out_slot <= '0;
          lead <= '0;
        end else begin
          lead <= lead - DW'(1);
          if (out_col + (CW+1)'(1) >= w_eff) begin
            out_col  <= '0;
            out_row  <= out_row + RWW'(1);
            out_slot <= (out_slot == SW'(SLOTS - 1)) ? '0 : out_slot + SW'(1);
          end else begin
            out_col <= out_col + (CW+1)'(1);
          end
        end
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.red_out   <= m_red;
      out_ch.green_out <= m_green;
      out_ch.blue_out  <= m_blue;
      out_ch.frame_end <= frame_last;
    end
  end

  sfgc_ram #(
    .WIDTH (sfgc_pkg::PIX_W),
    .DEPTH (LDEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr ({in_slot, in_col[CW-1:0]}),
    .wdata ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  sfgc_ram #(
    .WIDTH (sfgc_pkg::WEIGHT_W),
    .DEPTH (NKW)
  ) u_kernel_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (KAW'(in_ch.weight_index)),
    .wdata (in_ch.weight_value),
    .raddr (kbase + KAW'(tj)),
    .rdata (k_rdata)
  );

  sfgc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mac_ctrl),
    .pix   (l_rdata),
    .wt    (k_rdata),
    .busy  (mac_busy),
    .red   (m_red),
    .green (m_green),
    .blue  (m_blue)
  );

`ifndef SYNTHESIS
  a_tap_feeds_mac: assert property (@(posedge clk) disable iff (rst)
    (state == sfgc_pkg::S_TAP) |=> v1)
    else $error("tap read not followed by data valid");

  a_lead_bound: assert property (@(posedge clk) disable iff (rst)
    (DW+1)'(lead) <= (DW+1)'(lag) + (DW+1)'(1))
    else $error("input lead over output exceeds window lag");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    in_col < w_eff)
    else $error("input column beyond row width");
`endif

endmodule

/* rtl/sfgc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sfgc_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgc_mac
// Per-channel multiply-accumulate with rounding and saturation to 8 bits.
// ----------------------------------------------------------------------------
module sfgc_mac #(
  parameter int ACC_W = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sfgc_pkg::mac_ctrl_t           ctrl,
  input  logic [sfgc_pkg::PIX_W-1:0]    pix,
  input  logic [sfgc_pkg::WEIGHT_W-1:0] wt,
  output logic                          busy,
  output logic [sfgc_pkg::CHAN_W-1:0]   red,
  output logic [sfgc_pkg::CHAN_W-1:0]   green,
  output logic [sfgc_pkg::CHAN_W-1:0]   blue
);

  localparam int PW = sfgc_pkg::CHAN_W + sfgc_pkg::WEIGHT_W;
  localparam int CW = sfgc_pkg::CHAN_W;

  logic          pvalid;
  logic [PW-1:0] prod [3];
  logic [ACC_W-1:0] acc [3];
  logic [CW-1:0] chan [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= ctrl.take;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod[c] <= PW'(pix[(2-c)*CW +: CW]) * PW'(wt);
      if (ctrl.clear) begin
        acc[c] <= '0;
      end else if (pvalid) begin
        acc[c] <= acc[c] + ACC_W'(prod[c]);
      end
    end
  end

  always_comb begin
    logic [ACC_W:0] rnd;
    for (int c = 0; c < 3; c++) begin
      rnd = ((ACC_W+1)'(acc[c]) + (ACC_W+1)'(32768)) >> 16;
      chan[c] = (rnd > (ACC_W+1)'(255)) ? 8'd255 : CW'(rnd);
    end
  end

  assign busy  = pvalid;
  assign red   = chan[0];
  assign green = chan[1];
  assign blue  = chan[2];

endmodule
